// File: src/pola_pkg.sv
// ----------------------------------------------------------------------------
// pola_pkg
// Shared types and codes for the priority-ordered lock arbiter.
// ----------------------------------------------------------------------------
package pola_pkg;

  localparam int ID_BITS         = 16;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int COUNT_BITS      = 6;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_SRCH,
    S_SHIFT,
    S_FIN,
    S_GRANT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_BITS-1:0] requester_id;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  grant_valid;
    logic [ID_BITS-1:0]    grant_id;
    logic                  holding;
    logic [COUNT_BITS-1:0] waiting_count;
  } rsp_t;

endpackage

// File: src/pola_id_ram.sv
// ----------------------------------------------------------------------------
// pola_id_ram
// Queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pola_id_ram
  import pola_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int WIDTH = ID_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/priority_ordered_lock_arbiter_top.sv
// ----------------------------------------------------------------------------
// priority_ordered_lock_arbiter_top
// Lock arbiter over a sorted id queue held in a RAM; smallest id gets the lock.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_t  (kind, requester_id)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_t  (status, grant, count)
//
//  One item at a time.
//  Insert walks the queue tail to head, release searches head to tail then
//  shifts, one RAM entry per cycle; a grant adds one RAM read of the head.
//  Reset clears count and lock state; RAM contents past the count are never used.
//  A stalled result holds in the output register; the next item's result waits for it.
// ----------------------------------------------------------------------------
module priority_ordered_lock_arbiter_top
  import pola_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_W  = (CW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C    = CW'(1);
  localparam logic [CW:0]   ONE_W    = (CW+1)'(1);
  localparam logic [CW:0]   TWO_W    = (CW+1)'(2);

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic               lock_taken, lock_taken_next;
  logic [ID_BITS-1:0] holder, holder_next;
  logic [1:0]         stat, stat_next;
  logic               granted, granted_next;
  logic [ID_BITS-1:0] gid, gid_next;
  req_t               cur, cur_next;
  logic               rsp_valid_next;
  rsp_t               rsp_next;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ID_BITS-1:0] ram_wdata, ram_rdata;

  logic [CW:0]        idx_p1, idx_p2;
  logic [CW-1:0]      idx_m1, idx_m2;

  assign idx_p1 = {1'b0, idx} + ONE_W;
  assign idx_p2 = {1'b0, idx} + TWO_W;
  assign idx_m1 = idx - ONE_C;
  assign idx_m2 = idx - CW'(2);

  pola_id_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      lock_taken <= 1'b0;
      holder     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      lock_taken <= lock_taken_next;
      holder     <= holder_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    stat    <= stat_next;
    granted <= granted_next;
    gid     <= gid_next;
    cur     <= cur_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    lock_taken_next = lock_taken;
    holder_next     = holder;
    stat_next       = stat;
    granted_next    = granted;
    gid_next        = gid;
    cur_next        = cur;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && rsp_stall;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    req_stall       = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_next     = req;
          stat_next    = ST_OK;
          granted_next = 1'b0;
          gid_next     = '0;
          state_next   = S_FIN;
          case (req.kind)
            KIND_REQUEST: begin
              if (count == DEPTH_C) begin
                stat_next = ST_FULL;
              end else if (count == '0) begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = req.requester_id;
                count_next = ONE_C;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(count - ONE_C);
                idx_next   = count;
                state_next = S_INS;
              end
            end
            KIND_RELEASE: begin
              lock_taken_next = 1'b0;
              holder_next     = '0;
              if (count == '0) begin
                stat_next = ST_NOT_FOUND;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = S_SRCH;
              end
            end
            KIND_QUERY: begin
              state_next = S_FIN;
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx);
        if (ram_rdata >= cur.requester_id) begin
          ram_wdata = ram_rdata;
          if (idx == ONE_C) begin
            state_next = S_INS_HEAD;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_m2);
            idx_next  = idx_m1;
          end
        end else begin
          ram_wdata  = cur.requester_id;
          count_next = count + ONE_C;
          state_next = S_FIN;
        end
      end

      S_INS_HEAD: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = cur.requester_id;
        count_next = count + ONE_C;
        state_next = S_FIN;
      end

      S_SRCH: begin
        ram_re    = (idx_p1 < DEPTH_W);
        ram_raddr = AW'(idx_p1);
        if (ram_rdata == cur.requester_id) begin
          state_next = S_SHIFT;
        end else if (idx_p1 >= {1'b0, count}) begin
          stat_next  = ST_NOT_FOUND;
          state_next = S_FIN;
        end else begin
          idx_next = CW'(idx_p1);
        end
      end

      S_SHIFT: begin
        if (idx_p1 < {1'b0, count}) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx);
          ram_wdata = ram_rdata;
          ram_re    = (idx_p2 < DEPTH_W);
          ram_raddr = AW'(idx_p2);
          idx_next  = CW'(idx_p1);
        end else begin
          count_next = count - ONE_C;
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (!lock_taken && (count != '0)) begin
          ram_re     = 1'b1;
          ram_raddr  = '0;
          state_next = S_GRANT;
        end else begin
          state_next = S_RESULT;
        end
      end

      S_GRANT: begin
        lock_taken_next = 1'b1;
        holder_next     = ram_rdata;
        granted_next    = 1'b1;
        gid_next        = ram_rdata;
        state_next      = S_RESULT;
      end

      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next         = 1'b1;
          rsp_next.status        = stat;
          rsp_next.grant_valid   = granted;
          rsp_next.grant_id      = gid;
          rsp_next.holding       = lock_taken && (holder == cur.requester_id);
          rsp_next.waiting_count = COUNT_BITS'(count);
          state_next             = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/pola_checker.sv
// ----------------------------------------------------------------------------
// pola_checker
// Port-level checks for the priority-ordered lock arbiter.
// ----------------------------------------------------------------------------
module pola_checker
  import pola_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item accepted while previous item in progress");

  a_no_grant_zero_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.grant_valid |-> rsp.grant_id == '0)
    else $error("grant id nonzero without grant");

  a_missing_not_holding: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_NOT_FOUND) |-> !rsp.holding)
    else $error("released id reported as holder");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

bind priority_ordered_lock_arbiter_top pola_checker u_pola_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
